// ===== rtl/nlp_pkg.sv =====
// Shared types and constants for the numeric literal parser.
// No dependencies; imported by the controller, the datapath, the top level and the checker.
package nlp_pkg;

   localparam int CHAR_W      = 8;
   localparam int OUT_W       = 32;
   localparam int RADIX_W     = 6;
   localparam int PLACES_W    = 7;
   localparam int DIGIT_W     = 6;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 7;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_SELECT      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRACTION_ALLOWED = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAC_DIGITS      = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIGNED_MODE      = 2'd3;

   // characters
   localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
   localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UP_B   = 8'h42;
   localparam logic [CHAR_W-1:0] CH_UP_O   = 8'h4F;
   localparam logic [CHAR_W-1:0] CH_UP_X   = 8'h58;
   localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;
   localparam logic [CHAR_W-1:0] CASE_BIT  = 8'h20;

   // radix values
   localparam logic [RADIX_W-1:0] RADIX_NONE    = 6'd0;
   localparam logic [RADIX_W-1:0] RADIX_TWO     = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_EIGHT   = 6'd8;
   localparam logic [RADIX_W-1:0] RADIX_TEN     = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_SIXTEEN = 6'd16;
   localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;

   // result status codes
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_SYNTAX = 2'd1;
   localparam logic [1:0] STATUS_RANGE  = 2'd2;

   typedef enum logic [2:0] {
      ST_START,
      ST_SIGNED,
      ST_ZERO,
      ST_BODY_FIRST,
      ST_LEAD_DOT,
      ST_BODY,
      ST_PAD
   } fsm_state_type;

   typedef struct packed {
      logic [RADIX_W-1:0]  base_select;
      logic                fraction_allowed;
      logic [PLACES_W-1:0] frac_digits;
      logic                signed_mode;
   } cfg_type;

   // controller -> datapath
   typedef struct packed {
      logic               choose;        // latch radix and place count
      logic [RADIX_W-1:0] prefix_radix;  // RADIX_NONE when no prefix
      logic               body;          // character is a body character
      logic               set_sign;
      logic               negative;
      logic               term;          // terminator taken
      logic               phase_bad;     // terminator came with no body or a lone dot
      logic               pad;           // one zero-digit multiply
      logic               emit;          // load result, clear literal
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic pad_done;
      logic out_free;
   } dp_status_type;

   function automatic logic [CHAR_W-1:0] upper_case(input logic [CHAR_W-1:0] c);
      return c & ~CASE_BIT;
   endfunction

endpackage

// ===== rtl/numeric_literal_parser.sv =====
// A non-terminator character gives no result transaction. An accepted NUL terminator pads the
//   fraction digits still to keep (0..127) with zeros, stopping early on an error or overflow.
// Throughput: one character per cycle, but the input stalls from a terminator until its result
//   loads: padding reuses the single MAC unit, and a still-held previous result delays the load.
// Reset (synchronous, active high): config registers go to zero, the literal restarts with
//   radix ten, and any pending result is dropped.
module numeric_literal_parser
   import nlp_pkg::*;
#(
   parameter int VALUE_WIDTH = 32   // accumulator / range width, 8..64
)
(
   input  logic                   clock,
   input  logic                   reset,
   // character input
   input  logic                   req_valid,
   input  logic [CHAR_W-1:0]      req_character,
   output logic                   req_stall,
   // result output
   output logic                   rsp_valid,
   output logic [OUT_W-1:0]       rsp_value,
   output logic [1:0]             rsp_status,
   input  logic                   rsp_stall,
   // configuration writes
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output logic                   csr_ready
);

   cfg_type       cfg_ff, cfg_in;
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // Config writes are always taken. The datapath samples each field at the
   // point the literal needs it: radix and place count when the body starts,
   // fraction_allowed there and at a dot, signed_mode when the result is formed.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BASE_SELECT:      cfg_in.base_select      = csr_data[RADIX_W-1:0];
            CSR_FRACTION_ALLOWED: cfg_in.fraction_allowed = csr_data[0];
            CSR_FRAC_DIGITS:      cfg_in.frac_digits      = csr_data[PLACES_W-1:0];
            CSR_SIGNED_MODE:      cfg_in.signed_mode      = csr_data[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Phase tracking: sign, 0 prefix, first body character, padding loop.
   nlp_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_character (req_character),
      .req_stall     (req_stall),
      .dp_status     (dp_status),
      .dp_cmd        (dp_cmd)
   );

   // Digit decode, multiply-accumulate, flags and the output register that
   // lets the next literal start while a result transaction is still held.
   nlp_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_character (req_character),
      .dp_cmd        (dp_cmd),
      .dp_status     (dp_status),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_value     (rsp_value),
      .rsp_status    (rsp_status)
   );

endmodule

// ===== rtl/nlp_ctrl.sv =====
// Literal phase controller: tracks sign / prefix / body phases and the padding loop.
// Depends on nlp_pkg; drives dp_cmd_type commands into nlp_datapath.
module nlp_ctrl
   import nlp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [CHAR_W-1:0]   req_character,
   output logic                req_stall,
   input  dp_status_type       dp_status,
   output dp_cmd_type          dp_cmd
);

   fsm_state_type state_ff, state_in;

   logic              accept;
   logic [CHAR_W-1:0] up;
   logic              is_term, is_sign, is_zero, is_dot, is_prefix;

   assign req_stall = (state_ff == ST_PAD);
   assign accept    = req_valid & ~req_stall;

   assign up        = upper_case(req_character);
   assign is_term   = (req_character == CH_NUL);
   assign is_sign   = (req_character == CH_PLUS) || (req_character == CH_MINUS);
   assign is_zero   = (req_character == CH_ZERO);
   assign is_dot    = (req_character == CH_DOT);
   assign is_prefix = (up == CH_UP_X) || (up == CH_UP_B) || (up == CH_UP_O);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      if (accept) begin
         if (is_term) begin
            state_in = ST_PAD;
         end else begin
            case (state_ff)
               ST_START: begin
                  if (is_sign) state_in = ST_SIGNED;
                  else if (is_zero) state_in = ST_ZERO;
                  else state_in = is_dot ? ST_LEAD_DOT : ST_BODY;
               end
               ST_SIGNED: begin
                  if (is_zero) state_in = ST_ZERO;
                  else state_in = is_dot ? ST_LEAD_DOT : ST_BODY;
               end
               ST_ZERO: begin
                  state_in = is_prefix ? ST_BODY_FIRST : ST_BODY;
               end
               ST_BODY_FIRST: begin
                  state_in = is_dot ? ST_LEAD_DOT : ST_BODY;
               end
               ST_LEAD_DOT, ST_BODY: begin
                  state_in = ST_BODY;
               end
               default: begin
                  state_in = ST_START;
               end
            endcase
         end
      end else if (state_ff == ST_PAD) begin
         if (dp_status.pad_done && dp_status.out_free) state_in = ST_START;
      end
   end

   // datapath commands
   always_comb begin
      dp_cmd = '0;
      if (accept) begin
         if (is_term) begin
            dp_cmd.term         = 1'b1;
            dp_cmd.choose       = (state_ff == ST_ZERO);
            dp_cmd.prefix_radix = RADIX_NONE;
            dp_cmd.phase_bad    = !((state_ff == ST_ZERO) || (state_ff == ST_BODY));
         end else begin
            case (state_ff)
               ST_START: begin
                  if (is_sign) begin
                     dp_cmd.set_sign = 1'b1;
                     dp_cmd.negative = (req_character == CH_MINUS);
                  end else if (!is_zero) begin
                     dp_cmd.choose = 1'b1;
                     dp_cmd.body   = 1'b1;
                  end
               end
               ST_SIGNED: begin
                  if (!is_zero) begin
                     dp_cmd.choose = 1'b1;
                     dp_cmd.body   = 1'b1;
                  end
               end
               ST_ZERO: begin
                  dp_cmd.choose = 1'b1;
                  if (is_prefix) begin
                     if (up == CH_UP_X) dp_cmd.prefix_radix = RADIX_SIXTEEN;
                     else if (up == CH_UP_B) dp_cmd.prefix_radix = RADIX_TWO;
                     else dp_cmd.prefix_radix = RADIX_EIGHT;
                  end else begin
                     dp_cmd.body = 1'b1;
                  end
               end
               ST_BODY_FIRST, ST_LEAD_DOT, ST_BODY: begin
                  dp_cmd.body = 1'b1;
               end
               default: begin
                  dp_cmd.body = 1'b0;
               end
            endcase
         end
      end else if (state_ff == ST_PAD) begin
         if (!dp_status.pad_done) dp_cmd.pad = 1'b1;
         else if (dp_status.out_free) dp_cmd.emit = 1'b1;
      end
   end

endmodule

// ===== rtl/nlp_datapath.sv =====
// Parser datapath: digit decode, radix multiply-accumulate, flags, range check, result register.
// Depends on nlp_pkg; commanded by nlp_ctrl.
module nlp_datapath
   import nlp_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
)
(
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic [CHAR_W-1:0]   req_character,
   input  dp_cmd_type          dp_cmd,
   output dp_status_type       dp_status,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic [OUT_W-1:0]    rsp_value,
   output logic [1:0]          rsp_status
);

   localparam int MAC_W = VALUE_WIDTH + RADIX_W;
   localparam logic [VALUE_WIDTH-1:0] HALF = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
   localparam logic [CHAR_W-1:0] LETTER_BASE = 8'd10;

   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic                   overflowed_ff, overflowed_in;
   logic                   in_frac_ff, in_frac_in;
   logic [PLACES_W-1:0]    places_ff, places_in;
   logic                   negative_ff, negative_in;
   logic [RADIX_W-1:0]     radix_ff, radix_in;
   logic                   failed_ff, failed_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]       rsp_value_ff, rsp_value_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;

   logic [RADIX_W-1:0]     pick, rad_eff;
   logic [PLACES_W-1:0]    places_eff;
   logic                   base_set, choose_fail, failed_eff;
   logic [CHAR_W-1:0]      up;
   logic                   is_num, is_alpha, is_dot;
   logic [DIGIT_W-1:0]     digit, mac_digit;
   logic [MAC_W-1:0]       mac_full;
   logic                   mac_ovf;
   logic [VALUE_WIDTH-1:0] res_value;
   logic [1:0]             res_status;

   // radix choice at body start
   assign base_set    = (cfg.base_select != RADIX_NONE);
   assign pick        = base_set ? cfg.base_select
                      : ((dp_cmd.prefix_radix != RADIX_NONE) ? dp_cmd.prefix_radix : RADIX_TEN);
   assign choose_fail = (base_set && (dp_cmd.prefix_radix != RADIX_NONE)
                         && (cfg.base_select != dp_cmd.prefix_radix))
                      || (pick < RADIX_TWO) || (pick > RADIX_MAX);
   assign rad_eff     = dp_cmd.choose ? pick : radix_ff;
   assign places_eff  = dp_cmd.choose
                      ? (cfg.fraction_allowed ? cfg.frac_digits : '0)
                      : places_ff;
   assign failed_eff  = failed_ff | (dp_cmd.choose & choose_fail)
                      | (dp_cmd.term & dp_cmd.phase_bad);

   // digit decode, letters fold to upper case
   assign up       = upper_case(req_character);
   assign is_num   = (req_character >= CH_ZERO) && (req_character <= CH_NINE);
   assign is_alpha = (up >= CH_UP_A) && (up <= CH_UP_Z);
   assign is_dot   = (req_character == CH_DOT);
   assign digit    = is_num ? DIGIT_W'(req_character - CH_ZERO)
                            : DIGIT_W'(up - CH_UP_A + LETTER_BASE);

   // shared multiply-accumulate; padding feeds a zero digit
   assign mac_digit = dp_cmd.pad ? '0 : digit;
   assign mac_full  = MAC_W'(acc_ff) * MAC_W'(rad_eff) + MAC_W'(mac_digit);
   assign mac_ovf   = |mac_full[MAC_W-1:VALUE_WIDTH];

   assign dp_status.pad_done = failed_ff | overflowed_ff | (places_ff == '0);
   assign dp_status.out_free = ~rsp_valid_ff | ~rsp_stall;

   // final status and value
   always_comb begin
      res_value  = '0;
      res_status = STATUS_OK;
      if (failed_ff) begin
         res_status = STATUS_SYNTAX;
      end else if (overflowed_ff) begin
         res_status = STATUS_RANGE;
      end else if (negative_ff) begin
         if (cfg.signed_mode ? (acc_ff > HALF) : (acc_ff != '0)) res_status = STATUS_RANGE;
         else res_value = VALUE_WIDTH'(~acc_ff + 1'b1);
      end else begin
         if (cfg.signed_mode && acc_ff[VALUE_WIDTH-1]) res_status = STATUS_RANGE;
         else res_value = acc_ff;
      end
   end

   always_comb begin
      acc_in        = acc_ff;
      overflowed_in = overflowed_ff;
      in_frac_in    = in_frac_ff;
      places_in     = places_ff;
      negative_in   = negative_ff;
      radix_in      = radix_ff;
      failed_in     = failed_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      if (dp_cmd.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = OUT_W'(res_value);
         rsp_status_in = res_status;
         acc_in        = '0;
         overflowed_in = 1'b0;
         in_frac_in    = 1'b0;
         places_in     = '0;
         negative_in   = 1'b0;
         radix_in      = RADIX_TEN;
         failed_in     = 1'b0;
      end else begin
         if (dp_cmd.set_sign) negative_in = dp_cmd.negative;
         if (dp_cmd.choose) begin
            radix_in  = pick;
            places_in = places_eff;
         end
         failed_in = failed_eff;
         if (dp_cmd.body && !failed_eff) begin
            if (is_dot) begin
               if (in_frac_ff || !cfg.fraction_allowed) failed_in = 1'b1;
               else in_frac_in = 1'b1;
            end else if (!(is_num || is_alpha) || (digit >= rad_eff)) begin
               failed_in = 1'b1;
            end else begin
               if ((!in_frac_ff || (places_eff != '0)) && !overflowed_ff) begin
                  if (mac_ovf) overflowed_in = 1'b1;
                  else acc_in = mac_full[VALUE_WIDTH-1:0];
               end
               if (in_frac_ff && (places_eff != '0)) places_in = places_eff - 1'b1;
            end
         end
         if (dp_cmd.pad) begin
            if (mac_ovf) overflowed_in = 1'b1;
            else acc_in = mac_full[VALUE_WIDTH-1:0];
            places_in = places_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff        <= '0;
         overflowed_ff <= 1'b0;
         in_frac_ff    <= 1'b0;
         places_ff     <= '0;
         negative_ff   <= 1'b0;
         radix_ff      <= RADIX_TEN;
         failed_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         acc_ff        <= acc_in;
         overflowed_ff <= overflowed_in;
         in_frac_ff    <= in_frac_in;
         places_ff     <= places_in;
         negative_ff   <= negative_in;
         radix_ff      <= radix_in;
         failed_ff     <= failed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// ===== rtl/nlp_checker.sv =====
// Port-level checker for numeric_literal_parser, attached by bind.
// Depends on nlp_pkg and the top level's port names.
module nlp_checker
   import nlp_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic [CHAR_W-1:0]      req_character,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic [OUT_W-1:0]       rsp_value,
   input logic [1:0]             rsp_status,
   input logic                   rsp_stall
);

   // error results carry a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> (rsp_value == '0))
      else $error("error result with nonzero value");

   // only three status codes exist
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK) || (rsp_status == STATUS_SYNTAX)
                    || (rsp_status == STATUS_RANGE))
      else $error("undefined status code");

   // a terminator closes the literal and holds off input until the result loads
   a_term_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_character == CH_NUL) |=> req_stall)
      else $error("input not stalled after terminator");

   // held result does not move
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value) && $stable(rsp_status))
      else $error("stalled result changed");

   // reset drops any pending result
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind numeric_literal_parser nlp_checker u_nlp_checker (.*);

// ===== tb/numeric_literal_parser_test.sv =====
// Self-checking testbench for numeric_literal_parser: directed and random literals.
// Needs nlp_pkg and the numeric_literal_parser RTL; keeps its own parse model,
// compares every result transaction in order and fails if it reaches a cycle limit.
`timescale 1ns / 1ps

module numeric_literal_parser_test;
   import nlp_pkg::*;

   localparam int          VALUE_W      = 32;
   localparam logic [63:0] VALUE_MASK   = 64'h0000_0000_FFFF_FFFF;
   localparam logic [63:0] VALUE_HALF   = 64'h0000_0000_8000_0000;
   localparam int          GAP_MAX      = 17;
   localparam int          LONG_HOLD    = 300;    // receiver hold-off in cycles
   localparam int          DRAIN_CYCLES = 140;    // covers the longest pad, rounded up
   localparam int          SETTLE       = 4;      // quiet cycles before a register write
   localparam int          RANDOM_CHARS = 1650;
   localparam int          CYCLE_LIMIT  = 2000000;

   typedef struct packed {
      logic [OUT_W-1:0] value;
      logic [1:0]       status;
   } literal_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic [CHAR_W-1:0]      req_character = '0;
   logic                   req_stall;
   logic                   rsp_valid;
   logic [OUT_W-1:0]       rsp_value;
   logic [1:0]             rsp_status;
   logic                   rsp_stall = 1'b0;
   logic                   csr_valid = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;
   logic                   csr_ready;

   numeric_literal_parser #(.VALUE_WIDTH(VALUE_W)) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_character (req_character),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_value     (rsp_value),
      .rsp_status    (rsp_status),
      .rsp_stall     (rsp_stall),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .csr_ready     (csr_ready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Parse model: settings as last written, plus the per-literal state.
   // ------------------------------------------------------------------
   cfg_type            lit_cfg;
   fsm_state_type      lit_phase;
   logic [63:0]        lit_acc;
   bit                 lit_ovf;
   bit                 lit_in_frac;
   logic [PLACES_W-1:0] lit_places;
   bit                 lit_neg;
   logic [RADIX_W-1:0] lit_radix;
   bit                 lit_bad;

   literal_result_type parsed_q[$];   // results still owed by the block, oldest first

   // bookkeeping
   int unsigned cycle_count   = 0;
   int unsigned char_count    = 0;
   int unsigned literal_count = 0;
   int unsigned setting_count = 0;
   int unsigned mismatches    = 0;
   int unsigned status_seen[4] = '{0, 0, 0, 0};
   bit          req_gaps_on   = 1'b1;
   bit          rsp_gaps_on   = 1'b1;
   int unsigned hold_requests = 0;    // bumped by the pressure test

   function automatic void restart_literal();
      lit_phase   = ST_START;
      lit_acc     = '0;
      lit_ovf     = 1'b0;
      lit_in_frac = 1'b0;
      lit_places  = '0;
      lit_neg     = 1'b0;
      lit_radix   = RADIX_TEN;
      lit_bad     = 1'b0;
   endfunction

   // Radix and place count are latched once, when the body starts.
   function automatic void take_radix(input logic [RADIX_W-1:0] prefix);
      logic [RADIX_W-1:0] r;
      if (lit_cfg.base_select != RADIX_NONE && prefix != RADIX_NONE &&
          lit_cfg.base_select != prefix)
         lit_bad = 1'b1;
      r = (lit_cfg.base_select != RADIX_NONE) ? lit_cfg.base_select :
          (prefix != RADIX_NONE) ? prefix : RADIX_TEN;
      if (r < RADIX_TWO || r > RADIX_MAX)
         lit_bad = 1'b1;
      lit_radix  = r;
      lit_places = lit_cfg.fraction_allowed ? lit_cfg.frac_digits : '0;
   endfunction

   function automatic void shift_in_digit(input logic [63:0] digit);
      logic [63:0] r;
      r = {58'd0, lit_radix};
      if (lit_ovf || r < 64'd2)
         return;
      if (lit_acc > (VALUE_MASK - digit) / r)
         lit_ovf = 1'b1;
      else
         lit_acc = lit_acc * r + digit;
   endfunction

   function automatic void take_body_char(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] u;
      logic [CHAR_W-1:0] d;
      if (lit_bad)
         return;
      if (c == CH_DOT) begin
         if (lit_in_frac || !lit_cfg.fraction_allowed)
            lit_bad = 1'b1;
         else
            lit_in_frac = 1'b1;
         return;
      end
      u = c & ~CASE_BIT;
      if (c >= CH_ZERO && c <= CH_NINE)
         d = c - CH_ZERO;
      else if (u >= CH_UP_A && u <= CH_UP_Z)
         d = u - CH_UP_A + 8'd10;
      else begin
         lit_bad = 1'b1;
         return;
      end
      if (d >= lit_radix) begin
         lit_bad = 1'b1;
         return;
      end
      // fraction digits past the kept places are checked, then dropped
      if (!lit_in_frac || lit_places != 0)
         shift_in_digit({56'd0, d});
      if (lit_in_frac && lit_places != 0)
         lit_places--;
   endfunction

   function automatic void take_first_body(input logic [CHAR_W-1:0] c);
      take_body_char(c);
      lit_phase = (c == CH_DOT) ? ST_LEAD_DOT : ST_BODY;
   endfunction

   function automatic void close_literal(output literal_result_type res);
      logic [63:0] lim;
      if (lit_phase == ST_ZERO) begin
         take_radix(RADIX_NONE);
         lit_phase = ST_BODY;
      end
      if (lit_phase != ST_BODY)
         lit_bad = 1'b1;
      // pad the missing fraction digits with zeros
      while (!lit_bad && !lit_ovf && lit_places != 0) begin
         shift_in_digit(64'd0);
         lit_places--;
      end
      res.value  = '0;
      res.status = STATUS_OK;
      if (lit_bad)
         res.status = STATUS_SYNTAX;
      else if (lit_ovf)
         res.status = STATUS_RANGE;
      else if (lit_neg) begin
         lim = lit_cfg.signed_mode ? VALUE_HALF : 64'd0;
         if (lit_acc > lim)
            res.status = STATUS_RANGE;
         else
            res.value = ~lit_acc[OUT_W-1:0] + 1'b1;
      end else begin
         lim = lit_cfg.signed_mode ? VALUE_HALF - 64'd1 : VALUE_MASK;
         if (lit_acc > lim)
            res.status = STATUS_RANGE;
         else
            res.value = lit_acc[OUT_W-1:0];
      end
      restart_literal();
   endfunction

   // Returns 1 when the character is a terminator and res holds its result.
   function automatic bit parse_char(input logic [CHAR_W-1:0] c,
                                     output literal_result_type res);
      logic [CHAR_W-1:0] u;
      res = '0;
      if (c == CH_NUL) begin
         close_literal(res);
         return 1'b1;
      end
      case (lit_phase)
         ST_START, ST_SIGNED: begin
            if (lit_phase == ST_START && (c == CH_PLUS || c == CH_MINUS)) begin
               lit_neg   = (c == CH_MINUS);
               lit_phase = ST_SIGNED;
            end else if (c == CH_ZERO) begin
               lit_phase = ST_ZERO;
            end else begin
               take_radix(RADIX_NONE);
               take_first_body(c);
            end
         end
         ST_ZERO: begin
            u = c & ~CASE_BIT;
            if (u == CH_UP_X || u == CH_UP_B || u == CH_UP_O) begin
               take_radix(u == CH_UP_X ? RADIX_SIXTEEN :
                          u == CH_UP_B ? RADIX_TWO : RADIX_EIGHT);
               lit_phase = ST_BODY_FIRST;
            end else begin
               take_radix(RADIX_NONE);
               lit_phase = ST_BODY;
               take_body_char(c);
            end
         end
         ST_BODY_FIRST: take_first_body(c);
         default: begin
            take_body_char(c);
            lit_phase = ST_BODY;
         end
      endcase
      return 1'b0;
   endfunction

   // ------------------------------------------------------------------
   // Character sender. Valid stays up between back-to-back transactions;
   // the model runs at the edge where the character is taken.
   // ------------------------------------------------------------------
   task automatic send_char(input logic [CHAR_W-1:0] c);
      int gap;
      literal_result_type res;
      gap = req_gaps_on ? $urandom_range(0, GAP_MAX) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_character <= c;
      do @(posedge clock); while (req_stall);
      char_count++;
      if (parse_char(c, res)) begin
         parsed_q.push_back(res);
         literal_count++;
      end
   endtask

   task automatic send_literal(input string text);
      for (int i = 0; i < text.len(); i++)
         send_char(text[i]);
      send_char(CH_NUL);
   endtask

   // Sender pauses until every owed result is back, then lets the block settle.
   task automatic wait_results_done();
      req_valid <= 1'b0;
      while (parsed_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Writes all four registers back to back on the csr port, block idle.
   task automatic write_settings(input logic [RADIX_W-1:0] base, input bit frac_ok,
                                 input logic [PLACES_W-1:0] places, input bit signed_on);
      logic [CSR_INDEX_W-1:0] idx [4];
      logic [CSR_DATA_W-1:0]  data[4];
      idx[0] = CSR_BASE_SELECT;       data[0] = {1'b0, base};
      idx[1] = CSR_FRACTION_ALLOWED;  data[1] = {6'd0, frac_ok};
      idx[2] = CSR_FRAC_DIGITS;       data[2] = places;
      idx[3] = CSR_SIGNED_MODE;       data[3] = {6'd0, signed_on};
      wait_results_done();
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= data[i];
         do @(posedge clock); while (!csr_ready);
         case (idx[i])
            CSR_BASE_SELECT:      lit_cfg.base_select      = data[i][RADIX_W-1:0];
            CSR_FRACTION_ALLOWED: lit_cfg.fraction_allowed = data[i][0];
            CSR_FRAC_DIGITS:      lit_cfg.frac_digits      = data[i];
            default:              lit_cfg.signed_mode      = data[i][0];
         endcase
      end
      csr_valid <= 1'b0;
      setting_count++;
   endtask

   function automatic logic [CHAR_W-1:0] digit_char(input int d);
      logic [CHAR_W-1:0] ch;
      if (d < 10)
         return CH_ZERO + d[CHAR_W-1:0];
      ch = CH_UP_A + d[CHAR_W-1:0] - 8'd10;
      if ($urandom_range(0, 1) != 0)
         ch = ch | CASE_BIT;
      return ch;
   endfunction

   // One random literal: mostly well formed for the current settings, some broken.
   task automatic random_literal();
      logic [CHAR_W-1:0] text[$];
      logic [CHAR_W-1:0] letter;
      logic [63:0]       num;
      int                radix, prefix_radix, body_at, ndig, pos;
      bit                well;
      logic [RADIX_W-1:0] b;
      b     = lit_cfg.base_select;
      well  = ($urandom_range(0, 4) != 0);
      radix = (b >= RADIX_TWO && b <= RADIX_MAX) ? int'(b) : 10;
      case ($urandom_range(0, 2))
         0: text.push_back(CH_PLUS);
         1: text.push_back(CH_MINUS);
         default: ;
      endcase
      if ($urandom_range(0, 2) == 0) begin
         case ($urandom_range(0, 2))
            0: begin prefix_radix = int'(RADIX_SIXTEEN); letter = CH_UP_X; end
            1: begin prefix_radix = int'(RADIX_TWO);     letter = CH_UP_B; end
            default: begin prefix_radix = int'(RADIX_EIGHT); letter = CH_UP_O; end
         endcase
         if (b == RADIX_NONE || b == prefix_radix || !well) begin
            text.push_back(CH_ZERO);
            text.push_back($urandom_range(0, 1) ? (letter | CASE_BIT) : letter);
            if (b == RADIX_NONE)
               radix = prefix_radix;
         end
      end
      body_at = text.size();
      if ($urandom_range(0, 2) == 0) begin
         // a full-width value, sometimes right at the signed boundary
         if ($urandom_range(0, 3) == 0)
            num = VALUE_HALF + $urandom_range(0, 2) - 1;
         else
            num = {32'd0, $urandom()} >> $urandom_range(0, 31);
         do begin
            text.insert(body_at, digit_char(int'(num % radix)));
            num = num / radix;
         end while (num != 0);
      end else begin
         ndig = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
         repeat (ndig) text.push_back(digit_char($urandom_range(0, radix - 1)));
      end
      if (lit_cfg.fraction_allowed && $urandom_range(0, 1) != 0)
         text.insert($urandom_range(body_at, text.size()), CH_DOT);
      if (!well) begin
         case ($urandom_range(0, 3))
            0: text.insert($urandom_range(0, text.size()), CHAR_W'($urandom_range(1, 255)));
            1: text.insert($urandom_range(0, text.size()), CH_DOT);
            2: while (text.size() > body_at) void'(text.pop_back());
            default: begin
               pos = $urandom_range(body_at, text.size());
               if (radix < RADIX_MAX)
                  text.insert(pos, digit_char($urandom_range(radix, RADIX_MAX - 1)));
               else
                  text.insert(pos, CHAR_W'($urandom_range(1, 255)));
            end
         endcase
      end
      foreach (text[i])
         send_char(text[i]);
      send_char(CH_NUL);
   endtask

   // ------------------------------------------------------------------
   // Result side: receiver stall pattern and the in-order checker.
   // ------------------------------------------------------------------
   int          rsp_wait_left = 0;
   int          hold_left     = 0;
   int unsigned hold_served   = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_wait_left = 0;
         hold_left     = 0;
         rsp_stall    <= 1'b0;
      end else begin
         // long hold-off requested by the pressure test
         if (hold_served != hold_requests) begin
            hold_left   = LONG_HOLD;
            hold_served = hold_requests;
         end else if (hold_left != 0) begin
            hold_left--;
         end
         // fresh stall draw after each accepted result transaction
         if (rsp_valid && !rsp_stall)
            rsp_wait_left = rsp_gaps_on ? $urandom_range(0, GAP_MAX) : 0;
         else if (rsp_wait_left != 0)
            rsp_wait_left--;
         rsp_stall <= (rsp_wait_left != 0) || (hold_left != 0);
      end
   end

   task automatic note_mismatch(input string what, input logic [OUT_W-1:0] got,
                                input logic [OUT_W-1:0] want);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch on %s: got %h, expected %h (literal %0d)",
                  what, got, want, status_seen[0] + status_seen[1] + status_seen[2]);
   endtask

   always @(posedge clock) begin : check_results
      literal_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         status_seen[rsp_status]++;
         if (parsed_q.size() == 0) begin
            note_mismatch("unexpected result", rsp_value, '0);
         end else begin
            want = parsed_q.pop_front();
            if (rsp_value !== want.value)
               note_mismatch("value", rsp_value, want.value);
            if (rsp_status !== want.status)
               note_mismatch("status", {30'd0, rsp_status}, {30'd0, want.status});
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, parsed_q.size());
         $display("numeric_literal_parser_test failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset settings: auto radix, no fraction, unsigned range.
   task automatic test_plain_decimal();
      write_settings(RADIX_NONE, 1'b0, '0, 1'b0);
      send_literal("");              // empty body
      send_literal("+");             // sign alone
      send_literal("-0");            // negative zero is fine unsigned
      send_literal("4294967295");    // top of unsigned range
      send_literal("4294967296");    // one past: overflow
      send_literal("-1");            // negative in unsigned mode
      send_literal("99999999999z");  // syntax error outranks overflow
      send_char(8'hFF);              // highest byte, not a digit
      send_char(CH_NUL);
      send_char(8'h01);
      send_char(CH_NUL);
   endtask

   task automatic test_prefixes();
      send_literal("0b101");
      send_literal("-0O17");
      send_literal("0Xff");
      send_literal("0x");            // prefix alone
      send_literal("0b2");           // digit not below radix
      // prefix must agree with a set base, even if 'b' is a hex digit
      write_settings(RADIX_SIXTEEN, 1'b0, '0, 1'b0);
      send_literal("0x1F");
      send_literal("0b1");
   endtask

   task automatic test_radix_extremes();
      write_settings(RADIX_MAX, 1'b0, '0, 1'b0);
      send_literal("zZ");
      write_settings(6'd1, 1'b0, '0, 1'b0);   // below the smallest radix
      send_literal("1");
      write_settings(6'd63, 1'b0, '0, 1'b0);  // top of the field
      send_literal("5");
   endtask

   task automatic test_signed_range();
      write_settings(RADIX_NONE, 1'b0, '0, 1'b1);
      send_literal("2147483647");
      send_literal("2147483648");
      send_literal("-2147483648");
      send_literal("-2147483649");
   endtask

   task automatic test_fractions();
      write_settings(RADIX_TEN, 1'b1, 7'd2, 1'b0);
      send_literal("1.5");           // padded at the terminator
      send_literal("1.234");         // extra digit dropped
      send_literal("1.23x");         // dropped digits are still checked
      send_literal(".");             // dot alone
      send_literal("1..2");
      write_settings(RADIX_TEN, 1'b1, 7'd127, 1'b0);
      send_literal("1.");            // padding overflows
      send_literal("0.");            // longest pad, stays zero
      write_settings(RADIX_TEN, 1'b0, 7'd2, 1'b0);
      send_literal("1.5");           // dot not allowed
   endtask

   // Receiver holds off while the sender keeps offering characters, so the
   // result slot fills and the terminator backs up into the input.
   task automatic test_backpressure();
      write_settings(RADIX_NONE, 1'b1, 7'd1, 1'b1);
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      hold_requests++;
      repeat (12) random_literal();
      wait_results_done();
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   task automatic test_random_literals();
      int unsigned first_char;
      int unsigned phase_start;
      first_char = char_count;
      for (int p = 0; char_count - first_char < RANDOM_CHARS; p++) begin
         case (p)
            0: write_settings(RADIX_NONE,    1'b0, 7'd0,   1'b0);
            1: write_settings(RADIX_MAX,     1'b1, 7'd127, 1'b1);
            2: write_settings(RADIX_TEN,     1'b1, 7'd2,   1'b1);
            3: write_settings(RADIX_SIXTEEN, 1'b0, 7'd0,   1'b1);
            4: write_settings(RADIX_TWO,     1'b1, 7'd31,  1'b0);
            5: write_settings(6'd63,         1'b1, 7'd1,   1'b0);
            6: write_settings(6'd1,          1'b0, 7'd0,   1'b1);
            7: write_settings(RADIX_NONE,    1'b1, 7'd3,   1'b0);
            default:
               write_settings(RADIX_W'($urandom_range(0, 9) == 0 ? $urandom_range(0, 63)
                                                                 : $urandom_range(0, 36)),
                              1'($urandom_range(0, 1)),
                              PLACES_W'($urandom_range(0, 7) == 0 ? $urandom_range(0, 127)
                                                                  : $urandom_range(0, 3)),
                              1'($urandom_range(0, 1)));
         endcase
         phase_start = char_count;
         while (char_count - phase_start < RANDOM_CHARS / 10) begin
            // switch idling on and off so both busy and gappy stretches occur
            if ($urandom_range(0, 3) == 0) req_gaps_on = !req_gaps_on;
            if ($urandom_range(0, 3) == 0) rsp_gaps_on = !rsp_gaps_on;
            random_literal();
         end
      end
   endtask

   initial begin
      lit_cfg = '0;
      restart_literal();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_plain_decimal();
      test_prefixes();
      test_radix_extremes();
      test_signed_range();
      test_fractions();
      test_backpressure();
      test_random_literals();

      // everything sent: wait for the last results, then watch for strays
      wait_results_done();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d characters in %0d literals over %0d register settings",
               char_count, literal_count, setting_count);
      $display("results seen: %0d ok, %0d syntax, %0d range; %0d mismatches",
               status_seen[0], status_seen[1], status_seen[2], mismatches);
      if (mismatches == 0 && parsed_q.size() == 0) begin
         $display("numeric_literal_parser_test passed");
      end else begin
         $display("numeric_literal_parser_test failed");
      end
      $finish;
   end

endmodule
